/* hw/rtl/cts_pkg.sv */
package cts_pkg;

  // Opcodes of an input item
  localparam logic [1:0] OP_LOAD_FACTOR = 2'd0;
  localparam logic [1:0] OP_LOAD_RHS    = 2'd1;
  localparam logic [1:0] OP_SOLVE       = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIAG = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam int            SIZE_W     = 5;
  localparam logic [4:0]    SIZE_RESET = 5'd16;
  localparam int            Q_FRAC     = 16;
  // Divider: 32 quotient bits, wide dividend and divisor for the residual
  localparam int            DIV_STEPS  = 32;
  localparam int            NUM_W      = 66;
  localparam int            DEN_W      = 50;
  localparam logic [47:0]   SCALE_ONE  = 48'h0000_0001_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         row_index;
    logic [3:0]         column_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] solution_value;
    logic [3:0]         element_index;
    logic               last_flag;
    logic [1:0]         status;
    logic [31:0]        relative_residual;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIAG_RD, S_DIAG_CHK, S_ROW_INIT, S_ROW_LOAD, S_MAC_RD, S_MAC_MUL,
    S_MAC_ACC, S_ROW_END, S_DIV_LD, S_DIV_CHK, S_DIV_RUN, S_DIV_END, S_EMIT_RD,
    S_EMIT, S_ERR
  } state_t;

  typedef enum logic [2:0] {
    PH_FWD, PH_BWD, PH_TRN, PH_APP, PH_RES
  } phase_t;

endpackage

/* hw/rtl/cts_ram.sv */
module cts_ram
  #(parameter int WIDTH = 32,
    parameter int DEPTH = 16)
  (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/cholesky_triangular_solve.sv */
// Solves L L^T x = b in signed Q16.16 for a lower factor L and vector b loaded one
// entry per transfer. A solve transfer runs forward then backward substitution,
// forms L (L^T x) and reports the relative residual max|a - b| /
// max(1.0, max|a|, max|b|), then gives x one element per transfer, the residual
// on the last one. A nonpositive diagonal, or a value that leaves Q16.16 or the
// 64-bit accumulator, gives one error result instead. The work goes through one
// multiplier, one 64-bit accumulator and one shift-subtract divider (32 steps)
// under a sequencer, with L in a single-port-read RAM. The input is not ready
// while a solve runs; a size above MAX_SIZE acts as MAX_SIZE, zero as one.
module cholesky_triangular_solve
  import cts_pkg::*;
  #(parameter int MAX_SIZE = 16)
  (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam int IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CW  = $clog2(MAX_SIZE + 1);
  localparam int LD  = MAX_SIZE * MAX_SIZE;
  localparam int LAW = (LD > 1) ? $clog2(LD) : 1;

  function automatic logic [LAW-1:0] fac_addr(input logic [IW-1:0] row,
                                              input logic [IW-1:0] col);
    return LAW'(row) * LAW'(MAX_SIZE) + LAW'(col);
  endfunction

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [SIZE_W-1:0] size_r;
  logic [CW-1:0]     n_r, o_r, j_r, end_r, r_w, d_w;
  logic [1:0]        status_r;

  logic signed [63:0] acc_r, prod_r;
  logic signed [31:0] b_r;
  logic [48:0]        maxerr_r;
  logic [47:0]        scale_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r, rem_r;
  logic               qneg_r;
  logic [31:0]        low_r, quo_r, res_r;
  logic [4:0]         cnt_r;

  // Memory ports
  logic              fac_we, rhs_we, y_we, x_we, t_we;
  logic [LAW-1:0]    fac_waddr, fac_raddr;
  logic [IW-1:0]     rhs_waddr, y_raddr, x_raddr, x_waddr, vec_waddr;
  logic [31:0]       fac_q, rhs_q, y_q, x_q, t_q, div_val, t_val;
  logic signed [31:0] fac_s, vec_s;

  // Combinational datapath values
  logic               in_fire, out_fire, last_row, diag_bad;
  logic signed [63:0] prod_w, sum_w;
  logic               mac_ovf;
  logic [63:0]        acc_mag;
  logic [47:0]        sh_mag;
  logic               trn_fit, div_big, div_fit;
  logic signed [49:0] a_w, diff_w;
  logic [48:0]        err_w;
  logic [31:0]        bmag_w;
  logic [DEN_W:0]     trial_w;
  logic               qbit_w;
  logic               load_ok_row, load_ok_col;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign r_w      = n_r - o_r - CW'(1);
  assign d_w      = (phase_r == PH_BWD) ? r_w : o_r;
  assign last_row = (o_r == n_r - CW'(1));
  assign fac_s    = fac_q;
  assign diag_bad = (fac_s <= 32'sd0);

  // Pick the vector operand of a multiply-accumulate
  always_comb begin
    unique case (phase_r)
      PH_FWD:  vec_s = y_q;
      PH_APP:  vec_s = t_q;
      default: vec_s = x_q;
    endcase
  end

  assign prod_w = fac_s * vec_s;

  // Subtract for substitution, add for the products
  always_comb begin
    if (phase_r == PH_FWD || phase_r == PH_BWD) begin
      sum_w   = acc_r - prod_r;
      mac_ovf = (acc_r[63] != prod_r[63]) && (sum_w[63] != acc_r[63]);
    end else begin
      sum_w   = acc_r + prod_r;
      mac_ovf = (acc_r[63] == prod_r[63]) && (sum_w[63] != acc_r[63]);
    end
  end

  // Truncate the accumulator to Q16.16 toward zero
  assign acc_mag = acc_r[63] ? (~acc_r + 64'd1) : acc_r;
  assign sh_mag  = acc_mag[63:Q_FRAC];
  assign trn_fit = acc_r[63] ? (sh_mag <= 48'h0000_8000_0000)
                             : (sh_mag <= 48'h0000_7FFF_FFFF);
  assign t_val   = acc_r[63] ? (32'd0 - sh_mag[31:0]) : sh_mag[31:0];

  // Residual terms of one row
  assign a_w    = acc_r[63] ? (50'sd0 - $signed({2'b00, sh_mag}))
                            : $signed({2'b00, sh_mag});
  assign diff_w = a_w - 50'(b_r);
  assign err_w  = diff_w[49] ? 49'(50'sd0 - diff_w) : diff_w[48:0];
  assign bmag_w = b_r[31] ? (~b_r + 32'd1) : b_r;

  // Divider step and range checks
  assign div_big = ({16'd0, num_r} >= {den_r, 32'd0});
  assign trial_w = {rem_r, low_r[31]};
  assign qbit_w  = (trial_w >= {1'b0, den_r});
  assign div_fit = qneg_r ? (quo_r <= 32'h8000_0000) : (quo_r <= 32'h7FFF_FFFF);
  assign div_val = qneg_r ? (32'd0 - quo_r) : quo_r;

  // Load ranges
  assign load_ok_row = ({28'd0, in_data.row_index} < 32'(MAX_SIZE));
  assign load_ok_col = ({28'd0, in_data.column_index} < 32'(MAX_SIZE));

  // Memory writes
  assign fac_we    = in_fire && (in_data.opcode == OP_LOAD_FACTOR) && load_ok_row
                     && load_ok_col;
  assign fac_waddr = fac_addr(IW'(in_data.row_index), IW'(in_data.column_index));
  assign rhs_we    = in_fire && (in_data.opcode == OP_LOAD_RHS) && load_ok_row;
  assign rhs_waddr = IW'(in_data.row_index);
  assign y_we      = (state_r == S_DIV_END) && (phase_r == PH_FWD) && div_fit;
  assign x_we      = (state_r == S_DIV_END) && (phase_r == PH_BWD) && div_fit;
  assign x_waddr   = r_w[IW-1:0];
  assign t_we      = (state_r == S_ROW_END) && (phase_r == PH_TRN);
  assign vec_waddr = o_r[IW-1:0];

  // Memory read addresses
  always_comb begin
    fac_raddr = fac_addr(d_w[IW-1:0], d_w[IW-1:0]);
    unique case (state_r)
      S_DIAG_RD: fac_raddr = fac_addr(j_r[IW-1:0], j_r[IW-1:0]);
      S_MAC_RD: begin
        unique case (phase_r)
          PH_BWD:  fac_raddr = fac_addr(j_r[IW-1:0], r_w[IW-1:0]);
          PH_TRN:  fac_raddr = fac_addr(j_r[IW-1:0], o_r[IW-1:0]);
          default: fac_raddr = fac_addr(o_r[IW-1:0], j_r[IW-1:0]);
        endcase
      end
      default: ;
    endcase
  end

  assign y_raddr = (state_r == S_MAC_RD) ? j_r[IW-1:0] : r_w[IW-1:0];
  assign x_raddr = (state_r == S_MAC_RD) ? j_r[IW-1:0] : o_r[IW-1:0];

  cts_ram #(.WIDTH(32), .DEPTH(LD)) u_factor_store (
    .clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(in_data.value),
    .raddr(fac_raddr), .rdata(fac_q));

  cts_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_rhs_store (
    .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(in_data.value),
    .raddr(o_r[IW-1:0]), .rdata(rhs_q));

  cts_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_forward_store (
    .clk(clk), .we(y_we), .waddr(vec_waddr), .wdata(div_val),
    .raddr(y_raddr), .rdata(y_q));

  cts_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_solution_store (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(div_val),
    .raddr(x_raddr), .rdata(x_q));

  cts_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_transpose_product_store (
    .clk(clk), .we(t_we), .waddr(vec_waddr), .wdata(t_val),
    .raddr(j_r[IW-1:0]), .rdata(t_q));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_fire && in_data.opcode == OP_SOLVE) state_nxt = S_DIAG_RD;
      S_DIAG_RD:  state_nxt = S_DIAG_CHK;
      S_DIAG_CHK: begin
        if (diag_bad) state_nxt = S_ERR;
        else if (j_r == n_r - CW'(1)) state_nxt = S_ROW_INIT;
        else state_nxt = S_DIAG_RD;
      end
      S_ROW_INIT: state_nxt = S_ROW_LOAD;
      S_ROW_LOAD: state_nxt = (j_r < end_r) ? S_MAC_RD : S_ROW_END;
      S_MAC_RD:   state_nxt = S_MAC_MUL;
      S_MAC_MUL:  state_nxt = S_MAC_ACC;
      S_MAC_ACC: begin
        if (mac_ovf) state_nxt = S_ERR;
        else if (j_r + CW'(1) < end_r) state_nxt = S_MAC_RD;
        else state_nxt = S_ROW_END;
      end
      S_ROW_END: begin
        unique case (phase_r)
          PH_FWD, PH_BWD: state_nxt = S_DIV_LD;
          PH_TRN:  state_nxt = !trn_fit ? S_ERR : S_ROW_INIT;
          default: state_nxt = last_row ? S_DIV_LD : S_ROW_INIT;
        endcase
      end
      S_DIV_LD:   state_nxt = S_DIV_CHK;
      S_DIV_CHK: begin
        if (!div_big) state_nxt = S_DIV_RUN;
        else if (phase_r == PH_RES) state_nxt = S_EMIT_RD;
        else state_nxt = S_ERR;
      end
      S_DIV_RUN:  if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = S_DIV_END;
      S_DIV_END: begin
        if (phase_r == PH_RES) state_nxt = S_EMIT_RD;
        else if (!div_fit) state_nxt = S_ERR;
        else state_nxt = S_ROW_INIT;
      end
      S_EMIT_RD:  state_nxt = S_EMIT;
      S_EMIT:     if (out_fire) state_nxt = last_row ? S_IDLE : S_EMIT_RD;
      S_ERR:      if (out_fire) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = 1'b0;
    out_data  = '0;
    unique case (state_r)
      S_EMIT: begin
        out_valid                  = 1'b1;
        out_data.solution_value    = x_q;
        out_data.element_index     = 4'(o_r);
        out_data.last_flag         = last_row;
        out_data.status            = ST_OK;
        out_data.relative_residual = last_row ? res_r : 32'd0;
      end
      S_ERR: begin
        out_valid       = 1'b1;
        out_data.last_flag = 1'b1;
        out_data.status = status_r;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_FWD;
      size_r  <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (state_r == S_IDLE) begin
        phase_r <= PH_FWD;
      end else if (state_nxt == S_ROW_INIT && last_row
                   && (state_r == S_DIV_END || state_r == S_ROW_END)) begin
        unique case (phase_r)
          PH_FWD:  phase_r <= PH_BWD;
          PH_BWD:  phase_r <= PH_TRN;
          default: phase_r <= PH_APP;
        endcase
      end else if (state_r == S_ROW_END && phase_r == PH_APP && last_row) begin
        phase_r <= PH_RES;
      end
    end
  end

  // Counters and datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if ({27'd0, size_r} > 32'(MAX_SIZE)) n_r <= CW'(MAX_SIZE);
        else if (size_r == '0) n_r <= CW'(1);
        else n_r <= CW'(size_r);
        o_r      <= '0;
        j_r      <= '0;
        maxerr_r <= '0;
        scale_r  <= SCALE_ONE;
      end
      S_DIAG_CHK: begin
        j_r      <= j_r + CW'(1);
        status_r <= ST_BAD_DIAG;
      end
      S_ROW_INIT: begin
        unique case (phase_r)
          PH_FWD: begin j_r <= '0;              end_r <= o_r;            end
          PH_BWD: begin j_r <= r_w + CW'(1);    end_r <= n_r;            end
          PH_TRN: begin j_r <= o_r;             end_r <= n_r;            end
          default: begin j_r <= '0;             end_r <= o_r + CW'(1);   end
        endcase
      end
      S_ROW_LOAD: begin
        b_r <= rhs_q;
        unique case (phase_r)
          PH_FWD:  acc_r <= {{16{rhs_q[31]}}, rhs_q, 16'd0};
          PH_BWD:  acc_r <= {{16{y_q[31]}}, y_q, 16'd0};
          default: acc_r <= '0;
        endcase
      end
      S_MAC_MUL: prod_r <= prod_w;
      S_MAC_ACC: begin
        acc_r    <= sum_w;
        j_r      <= j_r + CW'(1);
        status_r <= ST_OVERFLOW;
      end
      S_ROW_END: begin
        status_r <= ST_OVERFLOW;
        if (phase_r == PH_APP) begin
          if (err_w > maxerr_r) maxerr_r <= err_w;
          if (sh_mag > scale_r && sh_mag >= 48'(bmag_w)) scale_r <= sh_mag;
          else if (48'(bmag_w) > scale_r) scale_r <= 48'(bmag_w);
        end
        if (phase_r == PH_TRN || phase_r == PH_APP) begin
          o_r <= last_row ? '0 : o_r + CW'(1);
        end
      end
      S_DIV_LD: begin
        if (phase_r == PH_RES) begin
          num_r  <= {1'b0, maxerr_r, 16'd0};
          den_r  <= {2'd0, scale_r};
          qneg_r <= 1'b0;
        end else begin
          num_r  <= {2'b00, acc_mag};
          den_r  <= {18'd0, fac_q};
          qneg_r <= acc_r[63];
        end
      end
      S_DIV_CHK: begin
        rem_r <= {16'd0, num_r[NUM_W-1:32]};
        low_r <= num_r[31:0];
        cnt_r <= '0;
        if (div_big) begin
          res_r <= '1;
          o_r   <= '0;
        end
      end
      S_DIV_RUN: begin
        rem_r <= qbit_w ? DEN_W'(trial_w - {1'b0, den_r}) : trial_w[DEN_W-1:0];
        quo_r <= {quo_r[30:0], qbit_w};
        low_r <= {low_r[30:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
      end
      S_DIV_END: begin
        if (phase_r == PH_RES) begin
          res_r <= quo_r;
          o_r   <= '0;
        end else begin
          o_r <= last_row ? '0 : o_r + CW'(1);
        end
      end
      S_EMIT: if (out_fire) o_r <= o_r + CW'(1);
      default: ;
    endcase
  end

endmodule

/* hw/rtl/cts_checker.sv */
module cts_checker
  import cts_pkg::*;
  (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Never take an item while a result is shown
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Residual and error status only on the last result
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_flag |->
      out_data.status == ST_OK && out_data.relative_residual == 32'd0)
    else $error("non-final result carries residual or error");

  // Error results are single and empty
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.last_flag && out_data.element_index == 4'd0
      && out_data.solution_value == 32'sd0)
    else $error("malformed error result");

  // Return to ready after the last transfer of a solve
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_flag |=> in_ready)
    else $error("not ready after last result");

endmodule

bind cholesky_triangular_solve cts_checker u_cts_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data));

/* dv/tb_cholesky_triangular_solve.sv */
`timescale 1ns / 1ps

module tb_cholesky_triangular_solve;
  import cts_pkg::*;

  localparam int N_MAX = 16;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

  // Solver scoreboard: mirrors the stores and predicts each solve
  class solve_scoreboard;
    int factor_mem[N_MAX][N_MAX];
    int rhs_mem[N_MAX];
    logic [SIZE_W-1:0] size_reg;
    out_item_t pending_q[$];
    int errors;
    int results_seen;

    function new();
      size_reg = SIZE_RESET;
      errors = 0;
      results_seen = 0;
      for (int i = 0; i < N_MAX; i++) begin
        rhs_mem[i] = 0;
        for (int k = 0; k < N_MAX; k++) factor_mem[i][k] = 0;
      end
    endfunction

    function void set_size(logic [SIZE_W-1:0] v);
      size_reg = v;
    endfunction

    function bit acc_add(inout longint acc, input longint p);
      if (p > 0 && acc > ACC_MAX - p) return 0;
      if (p < 0 && acc < ACC_MIN - p) return 0;
      acc += p;
      return 1;
    endfunction

    function bit fits_q16(longint v);
      return v >= -64'sd2147483648 && v <= 64'sd2147483647;
    endfunction

    function void push_error(logic [1:0] code);
      out_item_t r;
      r = '0;
      r.last_flag = 1'b1;
      r.status = code;
      pending_q.push_back(r);
    endfunction

    function void solve_system();
      int n, ri;
      longint acc, q, av, bv;
      longint unsigned maxerr, scale, e, whole, rem, res;
      int y[N_MAX];
      int x[N_MAX];
      int t[N_MAX];
      out_item_t r;
      n = (size_reg == 0) ? 1 : (size_reg > N_MAX) ? N_MAX : int'(size_reg);
      for (int i = 0; i < n; i++)
        if (factor_mem[i][i] <= 0) begin
          push_error(ST_BAD_DIAG);
          return;
        end
      // forward substitution
      for (int i = 0; i < n; i++) begin
        acc = longint'(rhs_mem[i]) * 65536;
        for (int k = 0; k < i; k++)
          if (!acc_add(acc, -(longint'(factor_mem[i][k]) * longint'(y[k])))) begin
            push_error(ST_OVERFLOW);
            return;
          end
        q = acc / longint'(factor_mem[i][i]);
        if (!fits_q16(q)) begin
          push_error(ST_OVERFLOW);
          return;
        end
        y[i] = int'(q);
      end
      // backward substitution
      for (int kk = 0; kk < n; kk++) begin
        ri = n - 1 - kk;
        acc = longint'(y[ri]) * 65536;
        for (int c = ri + 1; c < n; c++)
          if (!acc_add(acc, -(longint'(factor_mem[c][ri]) * longint'(x[c])))) begin
            push_error(ST_OVERFLOW);
            return;
          end
        q = acc / longint'(factor_mem[ri][ri]);
        if (!fits_q16(q)) begin
          push_error(ST_OVERFLOW);
          return;
        end
        x[ri] = int'(q);
      end
      // t = L^T x
      for (int k = 0; k < n; k++) begin
        acc = 0;
        for (int i = k; i < n; i++)
          if (!acc_add(acc, longint'(factor_mem[i][k]) * longint'(x[i]))) begin
            push_error(ST_OVERFLOW);
            return;
          end
        q = acc / 65536;
        if (!fits_q16(q)) begin
          push_error(ST_OVERFLOW);
          return;
        end
        t[k] = int'(q);
      end
      // a = L t, then the scaled max error
      maxerr = 0;
      scale = 65536;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        bv = rhs_mem[i];
        for (int k = 0; k <= i; k++)
          if (!acc_add(acc, longint'(factor_mem[i][k]) * longint'(t[k]))) begin
            push_error(ST_OVERFLOW);
            return;
          end
        av = acc / 65536;
        e = (av - bv < 0) ? -(av - bv) : (av - bv);
        if (e > maxerr) maxerr = e;
        if (longint'(av < 0 ? -av : av) > longint'(scale)) scale = av < 0 ? -av : av;
        if (longint'(bv < 0 ? -bv : bv) > longint'(scale)) scale = bv < 0 ? -bv : bv;
      end
      whole = maxerr / scale;
      rem = maxerr % scale;
      if (whole >= 65536) res = 64'hFFFF_FFFF;
      else res = (whole << 16) + ((rem << 16) / scale);
      if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
      for (int i = 0; i < n; i++) begin
        r.solution_value = x[i];
        r.element_index = i[3:0];
        r.last_flag = (i == n - 1);
        r.status = ST_OK;
        r.relative_residual = (i == n - 1) ? res[31:0] : 32'd0;
        pending_q.push_back(r);
      end
    endfunction

    function void note_input(in_item_t it);
      case (it.opcode)
        OP_LOAD_FACTOR: factor_mem[it.row_index][it.column_index] = it.value;
        OP_LOAD_RHS:    rhs_mem[it.row_index] = it.value;
        OP_SOLVE:       solve_system();
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.solution_value !== want.solution_value) begin
        $error("solution_value exp %h got %h", want.solution_value, got.solution_value);
        errors++;
      end
      if (got.element_index !== want.element_index) begin
        $error("element_index exp %0d got %0d", want.element_index, got.element_index);
        errors++;
      end
      if (got.last_flag !== want.last_flag) begin
        $error("last_flag exp %0b got %0b", want.last_flag, got.last_flag);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status exp %0d got %0d", want.status, got.status);
        errors++;
      end
      if (got.relative_residual !== want.relative_residual) begin
        $error("relative_residual exp %h got %h", want.relative_residual,
               got.relative_residual);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  in_item_t in_data;
  out_item_t out_data;
  logic [SIZE_W-1:0] cfg_wdata;

  solve_scoreboard sb;
  bit hold_req;
  bit no_idle;
  bit factor_written[N_MAX][N_MAX];
  bit rhs_written[N_MAX];
  bit matrix_clean;
  int items_sent;
  int active_n;

  cholesky_triangular_solve dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Offer one item and hold it until the transfer
  task send(logic [1:0] op, logic [3:0] row, logic [3:0] col, logic [31:0] val);
    in_item_t it;
    int gap;
    it.opcode = op;
    it.row_index = row;
    it.column_index = col;
    it.value = val;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
    if (op == OP_LOAD_FACTOR) factor_written[row][col] = 1'b1;
    if (op == OP_LOAD_RHS) rhs_written[row] = 1'b1;
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle
  task drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_size(logic [SIZE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_size(v);
    active_n = (v == 0) ? 1 : (v > N_MAX) ? N_MAX : int'(v);
  endtask

  function logic [31:0] well_offdiag();
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // Load a system of the active size (kind 0 well formed, 1 full range,
  // 2 nonpositive diagonal), with some noise, then start a solve
  task run_system(int kind);
    logic [31:0] v;
    int d;
    bit reload;
    for (int i = 0; i < active_n; i++) begin
      for (int k = 0; k <= i; k++) begin
        reload = !factor_written[i][k] || !matrix_clean || kind == 1
                 || $urandom_range(0, 3) == 0;
        if (reload) begin
          if (kind == 1) v = $urandom;
          else if (i == k) v = $urandom_range(32'h1_0000, 32'h4_0000);
          else v = well_offdiag();
          send(OP_LOAD_FACTOR, i, k, v);
        end
      end
      if (!rhs_written[i] || !matrix_clean || kind == 1 || $urandom_range(0, 3) == 0)
        send(OP_LOAD_RHS, i, 0,
             kind == 1 ? $urandom : $urandom_range(0, 32'h8_0000) - 32'h4_0000);
    end
    if ($urandom_range(0, 4) == 0) send(2'd3, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 4) == 0) begin
      d = $urandom_range(0, 14);
      send(OP_LOAD_FACTOR, d, $urandom_range(d + 1, 15), $urandom);
    end
    if (kind == 2) begin
      d = $urandom_range(0, active_n - 1);
      send(OP_LOAD_FACTOR, d, d, $urandom_range(0, 1) ? 32'd0 : 32'h8000_0000 | $urandom);
    end
    matrix_clean = (kind == 0);
    send(OP_SOLVE, $urandom, $urandom, $urandom);
  endtask

  task run_phase(logic [SIZE_W-1:0] sz, int quota);
    int kind, start;
    write_size(sz);
    start = items_sent;
    while (items_sent - start < quota) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 19);
      run_system(kind < 14 ? 0 : kind < 17 ? 1 : 2);
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = hold_req ? 600 : draw_gap();
      hold_req = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  initial begin
    logic [SIZE_W-1:0] sizes[8] = '{5'd3, 5'd0, 5'd2, 5'd5, 5'd1, 5'd16, 5'd31, 5'd4};
    sb = new();
    hold_req = 0;
    no_idle = 0;
    items_sent = 0;
    matrix_clean = 1;
    active_n = N_MAX;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one unknown, value extremes, bad diagonal, overflow, unused opcode
    write_size(5'd1);
    send(OP_LOAD_FACTOR, 0, 0, 32'h0001_0000);
    send(OP_LOAD_RHS, 0, 0, 32'h7FFF_FFFF);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_LOAD_RHS, 0, 0, 32'h8000_0000);
    send(OP_SOLVE, 15, 15, 32'hFFFF_FFFF);
    send(OP_LOAD_FACTOR, 0, 0, 32'd0);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_LOAD_FACTOR, 0, 0, 32'h8000_0000);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_LOAD_FACTOR, 0, 0, 32'd1);
    send(OP_LOAD_RHS, 0, 0, 32'h7FFF_FFFF);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_LOAD_FACTOR, 0, 0, 32'h7FFF_FFFF);
    send(OP_SOLVE, 0, 0, 0);
    send(2'd3, 15, 15, 32'hFFFF_FFFF);
    send(OP_LOAD_FACTOR, 0, 15, 32'h7FFF_FFFF);
    send(OP_LOAD_FACTOR, 15, 15, 32'h8000_0000);
    send(OP_LOAD_FACTOR, 0, 0, 32'h0002_0000);
    send(OP_SOLVE, 0, 0, 0);
    matrix_clean = 0;

    // Random: a run of size settings, then small sizes until enough results
    foreach (sizes[p]) begin
      if (sizes[p] == 5'd16) hold_req = 1;
      run_phase(sizes[p], 14);
    end
    while (items_sent < 130 || sb.results_seen < 48)
      run_phase($urandom_range(1, 6), 14);

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
